[hdl/ccda_pkg.sv]
// Shared types and constants for the cumulative counter delta accumulator.
`default_nettype none

package ccda_pkg;

  // Width of the saturating regression and unknown-interval counters
  localparam int unsigned CountWidth = 32;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned FieldCountWidth = 32;

  typedef enum logic [1:0] {
    ActObserve  = 2'd0,
    ActInterval = 2'd1,
    ActClear    = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    OutBaseline  = 3'd0,
    OutAdvanced  = 3'd1,
    OutSaturated = 3'd2,
    OutUnchanged = 3'd3,
    OutHeld      = 3'd4,
    OutRegressed = 3'd5,
    OutInterval  = 3'd6,
    OutCleared   = 3'd7
  } outcome_e;

  typedef logic [CountWidth-1:0] count_t;

  typedef struct packed {
    logic [1:0]            action;
    logic [ValueWidth-1:0] value;
    logic                  baseline_present;
  } req_t;

  typedef struct packed {
    logic [2:0]                 outcome;
    logic [ValueWidth-1:0]      total;
    logic [FieldCountWidth-1:0] unknown_count;
    logic [FieldCountWidth-1:0] regression_count;
    logic                       saturated_flag;
  } rsp_t;

endpackage

`default_nettype wire

[hdl/ccda_core.sv]
// Accumulator state and combinational update logic for one request.
`default_nettype none

module ccda_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  ccda_pkg::req_t req_i,
  input  logic          regression_resets_i,
  output ccda_pkg::rsp_t rsp_o
);
  import ccda_pkg::*;

  logic                  tracking_q, tracking_d;
  logic [ValueWidth-1:0] last_q, last_d;
  logic [ValueWidth-1:0] total_q, total_d;
  count_t                regress_q, regress_d;
  count_t                unknown_q, unknown_d;
  logic                  sat_q, sat_d;
  outcome_e              outcome;

  logic [ValueWidth:0]   diff;
  logic [ValueWidth:0]   sum;
  logic                  sample_eq;
  logic                  sample_lt;

  function automatic count_t count_bump(input count_t c);
    count_bump = (c == '1) ? c : c + count_t'(1);
  endfunction

  // Compare the sample with the baseline and form the forward step
  assign diff      = {1'b0, req_i.value} - {1'b0, last_q};
  assign sample_lt = diff[ValueWidth];
  assign sample_eq = (req_i.value == last_q);
  assign sum       = {1'b0, total_q} + {1'b0, diff[ValueWidth-1:0]};

  // Work out the state after this request
  always_comb begin
    tracking_d = tracking_q;
    last_d     = last_q;
    total_d    = total_q;
    regress_d  = regress_q;
    unknown_d  = unknown_q;
    sat_d      = sat_q;
    outcome    = OutUnchanged;
    unique case (action_e'(req_i.action))
      ActObserve: begin
        if (!tracking_q) begin
          tracking_d = 1'b1;
          last_d     = req_i.value;
          outcome    = OutBaseline;
        end else if (sample_eq) begin
          outcome = OutUnchanged;
        end else if (!sample_lt) begin
          last_d = req_i.value;
          if (sum[ValueWidth]) begin
            total_d = '1;
            sat_d   = 1'b1;
            outcome = OutSaturated;
          end else begin
            total_d = sum[ValueWidth-1:0];
            outcome = OutAdvanced;
          end
        end else begin
          regress_d = count_bump(regress_q);
          if (!regression_resets_i) begin
            outcome = OutHeld;
          end else begin
            unknown_d = count_bump(unknown_q);
            last_d    = req_i.value;
            outcome   = OutRegressed;
          end
        end
      end
      ActInterval: begin
        if (tracking_q) begin
          unknown_d = count_bump(unknown_q);
        end
        tracking_d = req_i.baseline_present;
        last_d     = req_i.baseline_present ? req_i.value : '0;
        outcome    = OutInterval;
      end
      ActClear: begin
        tracking_d = 1'b0;
        last_d     = '0;
        total_d    = '0;
        regress_d  = '0;
        unknown_d  = '0;
        sat_d      = 1'b0;
        outcome    = OutCleared;
      end
      default: begin
        outcome = OutUnchanged;
      end
    endcase
  end

  // Report the state as it stands after the request
  always_comb begin
    rsp_o.outcome          = outcome;
    rsp_o.total            = total_d;
    rsp_o.unknown_count    = FieldCountWidth'(unknown_d);
    rsp_o.regression_count = FieldCountWidth'(regress_d);
    rsp_o.saturated_flag   = sat_d;
  end

  // Advance the state when the request moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracking_q <= 1'b0;
      last_q     <= '0;
      total_q    <= '0;
      regress_q  <= '0;
      unknown_q  <= '0;
      sat_q      <= 1'b0;
    end else if (step_i) begin
      tracking_q <= tracking_d;
      last_q     <= last_d;
      total_q    <= total_d;
      regress_q  <= regress_d;
      unknown_q  <= unknown_d;
      sat_q      <= sat_d;
    end
  end

`ifndef NO_ASSERTIONS
  // A saturated total stays pinned at all ones until cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sat_q |-> (total_q == '1))
    else $error("saturated total is not all ones");

  // A held sample never moves the baseline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && outcome == OutHeld) |=> $stable(last_q) && $stable(unknown_q))
    else $error("held sample changed baseline or unknown count");
`endif

endmodule

`default_nettype wire

[hdl/cumulative_counter_delta_accumulator_top.sv]
// Top level: request register, result register and configuration bit.
`default_nettype none

// Accepts one request per clock unless the request side stalls, and returns
// one result per request via the request register and the result register.
// The sustained rate of one request a cycle is set by the state update loop
// in ccda_core: the baseline compare, the 64-bit subtract and the saturating
// 64-bit add complete in the cycle a request leaves the request register. The
// result register lets a new request enter while a finished result waits; the
// request side stalls only when both registers are full and the result is
// stalled. regression_resets resets to 1; the user writes it with cfg_we_i
// only while no request is in flight, which the block does not enforce.
module cumulative_counter_delta_accumulator_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_stall_o,
  input  ccda_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_stall_i,
  output ccda_pkg::rsp_t rsp_o,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i
);
  import ccda_pkg::*;

  logic in_valid_q, in_valid_d;
  req_t in_req_q;
  logic out_valid_q, out_valid_d;
  rsp_t out_rsp_q;
  rsp_t step_rsp;
  logic regression_resets_q;

  logic out_load;
  logic step;
  logic in_accept;

  // Move a request on when the result register is free or draining
  assign out_load    = !out_valid_q || !rsp_stall_i;
  assign step        = in_valid_q && out_load;
  assign req_stall_o = in_valid_q && !out_load;
  assign in_accept   = req_valid_i && !req_stall_o;

  assign in_valid_d  = in_accept ? 1'b1 : (step ? 1'b0 : in_valid_q);
  assign out_valid_d = step ? 1'b1 : (out_load ? 1'b0 : out_valid_q);

  ccda_core u_core (
    .clk_i,
    .rst_ni,
    .step_i              (step),
    .req_i               (in_req_q),
    .regression_resets_i (regression_resets_q),
    .rsp_o               (step_rsp)
  );

  // Hold the valid bits and the configuration bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q          <= 1'b0;
      out_valid_q         <= 1'b0;
      regression_resets_q <= 1'b1;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        regression_resets_q <= cfg_wdata_i;
      end
    end
  end

  // Capture request and result payloads
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_req_q <= req_i;
    end
    if (step) begin
      out_rsp_q <= step_rsp;
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_rsp_q;

`ifndef NO_ASSERTIONS
  // A request that leaves the request register shows up as a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> rsp_valid_o)
    else $error("stepped request produced no result");

  // A blocked request stays in the request register unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !step) |=> in_valid_q && $stable(in_req_q))
    else $error("blocked request lost or altered");

  // A flagged result always carries an all-ones total
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.saturated_flag) |-> (rsp_o.total == '1))
    else $error("saturated result with total below all ones");

  // Once saturated, a forward step can only report saturation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.outcome == OutAdvanced) |-> !rsp_o.saturated_flag)
    else $error("advance reported on a saturated total");
`endif

endmodule

`default_nettype wire
